### hdl/smmm_pkg.sv
// smmm_pkg: shared constants, control word types and the microprogram rom
// for the survey mean/median/mode core; no dependencies
package smmm_pkg;

	localparam int MAX_ITEMS   = 128;
	localparam int NUM_RATINGS = 9;
	localparam int Q_FRAC      = 8;

	localparam int RATING_W = 4;
	localparam int TOTAL_W  = $clog2(MAX_ITEMS * NUM_RATINGS + 1);
	localparam int COUNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int FREQ_W   = COUNT_W;
	localparam int MEAN_W   = 12;
	localparam int HIDX_W   = $clog2(NUM_RATINGS);
	localparam int DVD_W    = TOTAL_W + Q_FRAC;
	localparam int DCNT_W   = $clog2(DVD_W);
	localparam int STEP_W   = 3;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE = 3'd0;
	localparam step_t ST_ACC  = 3'd1;
	localparam step_t ST_INIT = 3'd2;
	localparam step_t ST_SCAN = 3'd3;
	localparam step_t ST_DIV  = 3'd4;
	localparam step_t ST_EMIT = 3'd5;
	localparam step_t ST_CLR  = 3'd6;

	typedef enum logic [2:0] {
		C_NEVER     = 3'd0,
		C_ALWAYS    = 3'd1,
		C_NO_ACCEPT = 3'd2,
		C_NOT_LAST  = 3'd3,
		C_SCAN_MORE = 3'd4,
		C_DIV_MORE  = 3'd5,
		C_OUT_FULL  = 3'd6
	} cond_t;

	typedef struct packed {
		logic take;
		logic acc;
		logic init;
		logic scan;
		logic div;
		logic emit;
		logic clr;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic last;
		logic scan_more;
		logic div_more;
		logic out_full;
	} stat_t;

	typedef struct packed {
		ctrl_t act;
		cond_t cond;
		step_t target;
	} uword_t;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '0;
		w.cond = C_ALWAYS;
		w.target = ST_IDLE;
		case (step)
			ST_IDLE: begin
				w.act.take = 1'b1;
				w.cond = C_NO_ACCEPT;
				w.target = ST_IDLE;
			end
			ST_ACC: begin
				w.act.acc = 1'b1;
				w.cond = C_NOT_LAST;
				w.target = ST_IDLE;
			end
			ST_INIT: begin
				w.act.init = 1'b1;
				w.cond = C_NEVER;
			end
			ST_SCAN: begin
				w.act.scan = 1'b1;
				w.cond = C_SCAN_MORE;
				w.target = ST_SCAN;
			end
			ST_DIV: begin
				w.act.div = 1'b1;
				w.cond = C_DIV_MORE;
				w.target = ST_DIV;
			end
			ST_EMIT: begin
				w.act.emit = 1'b1;
				w.cond = C_OUT_FULL;
				w.target = ST_EMIT;
			end
			ST_CLR: begin
				w.act.clr = 1'b1;
				w.cond = C_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### hdl/smmm_seq.sv
// smmm_seq: step counter and microprogram rom with conditional jumps
// depends on smmm_pkg
module smmm_seq
	import smmm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t  pc_q;
	uword_t uw;
	logic   jump;

	assign uw   = ucode(pc_q);
	assign ctrl = uw.act;

	always_comb begin
		unique case (uw.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_ACCEPT: jump = !stat.accept;
			C_NOT_LAST:  jump = !stat.last;
			C_SCAN_MORE: jump = stat.scan_more;
			C_DIV_MORE:  jump = stat.div_more;
			C_OUT_FULL:  jump = stat.out_full;
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (jump) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + step_t'(1);
		end
	end

endmodule

### hdl/smmm_dp.sv
// smmm_dp: histogram, running total and count, scan unit, restoring divider
// and output register, driven by the control word; depends on smmm_pkg
module smmm_dp
	import smmm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	output stat_t               stat,
	input  logic                in_valid,
	input  logic [RATING_W-1:0] in_rating,
	input  logic                in_last,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [TOTAL_W-1:0]  out_total,
	output logic [COUNT_W-1:0]  out_count,
	output logic [MEAN_W-1:0]   out_mean,
	output logic [RATING_W-1:0] out_median,
	output logic [RATING_W-1:0] out_mode,
	output logic [FREQ_W-1:0]   out_freq,
	output logic                out_ovf
);

	logic [FREQ_W-1:0]   hist_q [NUM_RATINGS];
	logic [TOTAL_W-1:0]  total_q;
	logic [COUNT_W-1:0]  count_q;
	logic                dropped_q;
	logic                out_valid_q;

	logic [RATING_W-1:0] rating_q;
	logic                last_q;
	logic [HIDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0]  cum_q;
	logic                found_q;
	logic [RATING_W-1:0] med_q;
	logic [RATING_W-1:0] mval_q;
	logic [FREQ_W-1:0]   mfreq_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic                accept;
	logic                rating_ok;
	logic                full;
	logic [HIDX_W-1:0]   ra_idx;
	logic [HIDX_W-1:0]   rd_idx;
	logic [FREQ_W-1:0]   h;
	logic                hist_we;
	logic [HIDX_W-1:0]   wr_idx;
	logic [FREQ_W-1:0]   wr_data;
	logic [COUNT_W-1:0]  cum_d;
	logic [RATING_W-1:0] idx_rating;
	logic [COUNT_W:0]    rem_sh;
	logic                ge;
	logic [COUNT_W-1:0]  rem_d;
	logic                out_full;
	logic                load_out;

	assign accept     = in_valid && ctrl.take;
	assign rating_ok  = (rating_q != '0) && (rating_q <= RATING_W'(NUM_RATINGS));
	assign full       = (count_q == COUNT_W'(MAX_ITEMS));
	assign ra_idx     = HIDX_W'(rating_q - RATING_W'(1));
	assign rd_idx     = ctrl.scan ? idx_q : ra_idx;
	assign h          = hist_q[rd_idx];
	assign hist_we    = (ctrl.acc && rating_ok && !full) || ctrl.scan;
	assign wr_idx     = rd_idx;
	assign wr_data    = ctrl.scan ? '0 : h + FREQ_W'(1);
	assign cum_d      = cum_q + COUNT_W'(h);
	assign idx_rating = RATING_W'(idx_q) + RATING_W'(1);
	assign rem_sh     = {rem_q, dvd_q[DVD_W-1]};
	assign ge         = rem_sh >= {1'b0, count_q};
	assign rem_d      = ge ? COUNT_W'(rem_sh - {1'b0, count_q}) : COUNT_W'(rem_sh);
	assign out_full   = out_valid_q && !out_ready;
	assign load_out   = ctrl.emit && !out_full;

	assign stat.accept    = accept;
	assign stat.last      = last_q;
	assign stat.scan_more = (idx_q != HIDX_W'(NUM_RATINGS - 1));
	assign stat.div_more  = (dcnt_q != DCNT_W'(DVD_W - 1));
	assign stat.out_full  = out_full;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RATINGS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (hist_we) begin
			hist_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.acc && rating_ok) begin
				if (!full) begin
					total_q <= total_q + TOTAL_W'(rating_q);
					count_q <= count_q + COUNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (ctrl.clr) begin
				total_q   <= '0;
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rating_q <= in_rating;
			last_q   <= in_last;
		end
		if (ctrl.init) begin
			idx_q   <= '0;
			cum_q   <= '0;
			found_q <= 1'b0;
			med_q   <= '0;
			mval_q  <= '0;
			mfreq_q <= '0;
			dvd_q   <= {total_q, Q_FRAC'(0)};
			rem_q   <= '0;
			dcnt_q  <= '0;
		end
		if (ctrl.scan) begin
			idx_q <= idx_q + HIDX_W'(1);
			cum_q <= cum_d;
			if (!found_q && (cum_d > (count_q >> 1))) begin
				found_q <= 1'b1;
				med_q   <= idx_rating;
			end
			if (h > mfreq_q) begin
				mfreq_q <= h;
				mval_q  <= idx_rating;
			end
		end
		if (ctrl.div) begin
			rem_q  <= rem_d;
			dvd_q  <= {dvd_q[DVD_W-2:0], ge};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (load_out) begin
			out_total  <= total_q;
			out_count  <= count_q;
			out_mean   <= (count_q == '0) ? '0 : dvd_q[MEAN_W-1:0];
			out_median <= med_q;
			out_mode   <= mval_q;
			out_freq   <= mfreq_q;
			out_ovf    <= dropped_q;
		end
	end

endmodule

### hdl/survey_mean_median_mode_core.sv
// survey_mean_median_mode_core: top level, microcoded sequencer plus datapath
// depends on smmm_pkg, smmm_seq and smmm_dp
//
// usage:
//   s_axis carries one rating word per transfer, tlast closes a data set.
//   m_axis carries one result word per data set.
//   a rating word is taken in the idle step, and the histogram, total and count
//   are updated in the acc step, so s_axis_tready is low while a word is counted.
//   after the word with tlast the program scans the 9 histogram bins (the bins
//   are zeroed as they are read) and runs a restoring divider for the mean (one
//   quotient bit per cycle).
//   the result is loaded in the emit step after the divider; a clear step
//   then resets total, count and overflow before the next set starts.
//   the result sits in an output register, so the next set may stream in
//   while it waits; a second result stalls the program until m_axis_tready.
//   out-of-range ratings are ignored, ratings past 128 are dropped and set
//   overflow. an empty set gives zeros with overflow as seen.
//   reset clears the histogram, total, count, overflow flag and output valid.
module survey_mean_median_mode_core
	import smmm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rating[3:0], zero [7:4]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // total[10:0], item_count[18:11], mean_q8[30:19],
	                                   // median_value[34:31], mode_value[38:35],
	                                   // mode_frequency[46:39], overflow[47]
);

	ctrl_t               ctrl;
	stat_t               stat;
	logic [TOTAL_W-1:0]  total;
	logic [COUNT_W-1:0]  item_count;
	logic [MEAN_W-1:0]   mean_q8;
	logic [RATING_W-1:0] median_value;
	logic [RATING_W-1:0] mode_value;
	logic [FREQ_W-1:0]   mode_frequency;
	logic                overflow;

	smmm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	smmm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.in_valid   (s_axis_tvalid),
		.in_rating  (s_axis_tdata[RATING_W-1:0]),
		.in_last    (s_axis_tlast),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_total  (total),
		.out_count  (item_count),
		.out_mean   (mean_q8),
		.out_median (median_value),
		.out_mode   (mode_value),
		.out_freq   (mode_frequency),
		.out_ovf    (overflow)
	);

	assign s_axis_tready = ctrl.take;
	assign m_axis_tdata  = {overflow, mode_frequency, mode_value, median_value,
		mean_q8, item_count, total};

`ifndef SYNTHESIS
	a_one_word_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken in two consecutive cycles");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && !stat.out_full |=> m_axis_tvalid)
		else $error("result load did not raise m_axis_tvalid");

	a_valid_only_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctrl.emit))
		else $error("m_axis_tvalid rose without a result load");
`endif

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking bench for survey_mean_median_mode_core, rating words in, one
// statistics word per data set out, compared against an in-bench histogram model
// depends on smmm_pkg and the core under hdl/
module tb_top
	import smmm_pkg::*;
();

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RAND_WORDS   = 1050;

	typedef struct {
		logic [RATING_W-1:0] rating;
		logic                last;
	} rating_word_t;

	typedef struct {
		logic [TOTAL_W-1:0]  total;
		logic [COUNT_W-1:0]  item_count;
		logic [MEAN_W-1:0]   mean_q8;
		logic [RATING_W-1:0] median_value;
		logic [RATING_W-1:0] mode_value;
		logic [FREQ_W-1:0]   mode_frequency;
		logic                overflow;
	} set_stats_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // rating[3:0], zero [7:4]
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // total, item_count, mean_q8, median_value, mode_value,
	                            // mode_frequency, overflow

	rating_word_t rating_words[$];
	set_stats_t   pending_stats[$];

	// histogram model of the set in progress
	int bin_cnt[1:NUM_RATINGS];
	int sum_acc;
	int n_acc;
	bit drop_seen;

	bit stim_loaded;
	bit in_fire;
	int gap_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	bit in_quiet;
	bit out_quiet;
	int cycles;
	int errors;
	int words_sent;
	int results_seen;
	int overflow_sets;
	int empty_sets;
	int ignored_words;

	survey_mean_median_mode_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		else if (k < 90)
			return $urandom_range(1, 3);
		else if (k < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void push_word(input int rating, input bit last);
		rating_word_t w;
		w.rating = rating[RATING_W-1:0];
		w.last = last;
		rating_words.push_back(w);
	endfunction

	function automatic int pick_rating(input int favorite);
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(NUM_RATINGS + 1, 15);
		if (favorite != 0 && $urandom_range(0, 1) == 0)
			return favorite;
		return $urandom_range(1, NUM_RATINGS);
	endfunction

	task automatic tally_rating(input logic [RATING_W-1:0] rating, input logic last);
		set_stats_t st;
		int r;
		int cum;
		int best;
		bit med_found;
		st = '{default: '0};
		if (rating >= 1 && rating <= NUM_RATINGS) begin
			if (n_acc < MAX_ITEMS) begin
				bin_cnt[rating] += 1;
				sum_acc += int'(rating);
				n_acc += 1;
			end else begin
				drop_seen = 1'b1;
			end
		end else begin
			ignored_words++;
		end
		if (last) begin
			if (n_acc != 0) begin
				cum = 0;
				best = 0;
				med_found = 1'b0;
				for (r = 1; r <= NUM_RATINGS; r++) begin
					cum += bin_cnt[r];
					if (!med_found && cum > n_acc / 2) begin
						st.median_value = r[RATING_W-1:0];
						med_found = 1'b1;
					end
					if (bin_cnt[r] > best) begin
						best = bin_cnt[r];
						st.mode_value = r[RATING_W-1:0];
					end
				end
				st.mode_frequency = best[FREQ_W-1:0];
				st.mean_q8 = MEAN_W'((sum_acc * 256) / n_acc);
			end
			st.total = sum_acc[TOTAL_W-1:0];
			st.item_count = n_acc[COUNT_W-1:0];
			st.overflow = drop_seen;
			pending_stats.push_back(st);
			for (r = 1; r <= NUM_RATINGS; r++)
				bin_cnt[r] = 0;
			sum_acc = 0;
			n_acc = 0;
			drop_seen = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		errors++;
		$display("[%0d] %s: got %0d, expected %0d", cycles, field, got, want);
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && stim_loaded) begin
			if (in_fire) begin
				void'(rating_words.pop_front());
				words_sent++;
				if ($urandom_range(0, 149) == 0)
					in_quiet = !in_quiet;
				gap_left = in_quiet ? 0 : pick_gap();
			end
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (rating_words.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0000, rating_words[0].rating};
				s_axis_tlast <= rating_words[0].last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off once results are flowing
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 8) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 99) == 0)
					out_quiet = !out_quiet;
				if (!out_quiet && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// input and output monitors
	always @(posedge clk) begin
		set_stats_t want;
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_fire)
			tally_rating(s_axis_tdata[RATING_W-1:0], s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_stats.size() == 0) begin
				report_mismatch("result word with no set closed", 1, 0);
			end else begin
				want = pending_stats.pop_front();
				if (want.overflow)
					overflow_sets++;
				if (want.item_count == 0)
					empty_sets++;
				if (m_axis_tdata[10:0] !== want.total)
					report_mismatch("total", int'(m_axis_tdata[10:0]), int'(want.total));
				if (m_axis_tdata[18:11] !== want.item_count)
					report_mismatch("item_count", int'(m_axis_tdata[18:11]),
						int'(want.item_count));
				if (m_axis_tdata[30:19] !== want.mean_q8)
					report_mismatch("mean_q8", int'(m_axis_tdata[30:19]),
						int'(want.mean_q8));
				if (m_axis_tdata[34:31] !== want.median_value)
					report_mismatch("median_value", int'(m_axis_tdata[34:31]),
						int'(want.median_value));
				if (m_axis_tdata[38:35] !== want.mode_value)
					report_mismatch("mode_value", int'(m_axis_tdata[38:35]),
						int'(want.mode_value));
				if (m_axis_tdata[46:39] !== want.mode_frequency)
					report_mismatch("mode_frequency", int'(m_axis_tdata[46:39]),
						int'(want.mode_frequency));
				if (m_axis_tdata[47] !== want.overflow)
					report_mismatch("overflow", int'(m_axis_tdata[47]),
						int'(want.overflow));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_stats.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int i;
		int n;
		int k;
		int favorite;
		int budget;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		for (i = 1; i <= NUM_RATINGS; i++)
			bin_cnt[i] = 0;
		sum_acc = 0;
		n_acc = 0;
		drop_seen = 1'b0;

		// single rating, empty sets closed by zero and by an out-of-range rating
		push_word(5, 1'b1);
		push_word(0, 1'b1);
		push_word(15, 1'b1);
		// every rating once, nine-way tie resolved to the lowest
		for (i = 1; i <= NUM_RATINGS; i++)
			push_word(i, i == NUM_RATINGS);
		// tie between 3 and 7, closed by an ignored rating
		push_word(3, 1'b0);
		push_word(7, 1'b0);
		push_word(3, 1'b0);
		push_word(7, 1'b0);
		push_word(12, 1'b1);
		push_word(9, 1'b0);
		push_word(9, 1'b0);
		push_word(1, 1'b1);
		// full capacity of top ratings plus two dropped words
		for (i = 0; i < MAX_ITEMS + 2; i++)
			push_word(NUM_RATINGS, i == MAX_ITEMS + 1);

		budget = 0;
		while (budget < RAND_WORDS) begin
			k = $urandom_range(0, 99);
			if (k < 85)
				n = $urandom_range(1, 16);
			else if (k < 95)
				n = $urandom_range(17, 60);
			else
				n = $urandom_range(MAX_ITEMS - 3, MAX_ITEMS + 12);
			favorite = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NUM_RATINGS) : 0;
			for (i = 0; i < n; i++)
				push_word(pick_rating(favorite), i == n - 1);
			budget += n;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		stim_loaded = 1'b1;

		while (rating_words.size() > 0 || pending_stats.size() > 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("%0d rating words sent, %0d out of range; %0d sets checked", words_sent,
			ignored_words, results_seen);
		$display("%0d sets hit capacity, %0d sets were empty", overflow_sets, empty_sets);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
